[src/combined_lcg_shuffled_prng_top_assert.svh]
// Assertion macros shared by the generator modules.
// Each expects clk_i and rst_ni in scope.
`ifndef COMBINED_LCG_SHUFFLED_PRNG_TOP_ASSERT_SVH
`define COMBINED_LCG_SHUFFLED_PRNG_TOP_ASSERT_SVH

// Same-cycle implication
`define CLSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CLSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/clsp_pkg.sv]
`default_nettype none
package clsp_pkg;

  // Moduli and multipliers of the two congruential generators
  localparam logic [31:0] MOD_ONE  = 32'd2147483563;
  localparam logic [31:0] MOD_TWO  = 32'd2147483399;
  localparam logic [15:0] MUL_ONE  = 16'd40014;
  localparam logic [15:0] MUL_TWO  = 16'd40692;

  // 2^31 mod M for each modulus, used to fold the upper product bits
  localparam logic [31:0] FOLD_ONE = 32'd85;
  localparam logic [31:0] FOLD_TWO = 32'd249;

  // Output wrap constant and reset seed of the second generator
  localparam logic [31:0] WRAP_ADD = 32'd2147483562;
  localparam logic [30:0] TWO_SEED = 31'd123456789;

  // Warm-up steps beyond the table fill on a reseed
  localparam int unsigned WARMUP_EXTRA = 8;

  // Product widths: 31-bit state times 16-bit multiplier
  localparam int unsigned PROD_W = 47;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_DRAW_MUL,
    ST_DRAW_RED
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;         // load both generators with the seed, arm warm-up count
    logic load_one;     // seed is one instead of the input seed
    logic mul_en;       // launch products, compute slot, read table
    logic warm_step;    // commit one warm-up step of the first generator
    logic draw_commit;  // commit a draw: state, table slot, result registers
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic gen_one_zero;  // stored first generator is zero
    logic red_one_zero;  // reduced first generator about to commit is zero
    logic cnt_zero;      // warm-up counter at its last step
  } dp_sts_t;

endpackage
`default_nettype wire

[src/combined_lcg_shuffled_prng_top.sv]
// Combined congruential generator (moduli 2147483563 and 2147483399) with an
// output shuffle table of TABLE_DEPTH entries. Each input item is a draw
// (tuser 0) or a reseed-then-draw (tuser 1, seed in tdata, zero acts as one);
// each gives one result: the shuffled value 1..2147483562 (fraction value /
// 2147483563) and the updated first generator state. A draw has a multiply
// state (two 31x16 constant multiplies, table read) and a reduce state
// (modular fold, output wrap, table refill); the next item is taken as a
// draw commits, and a commit waits while the held result is not taken. A
// reseed adds a warm-up on the single first-generator multiply-mod loop. A
// draw while the first generator is zero, as after reset, reseeds with one
// first. No clearing pass follows reset.
`default_nettype none
module combined_lcg_shuffled_prng_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [30:0] seed_value, [31] zero
  input  wire logic        s_axis_tuser,   // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // [30:0] value, [61:31] first_state, [63:62] zero
);
  import clsp_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [30:0] value;
  logic [30:0] first_state;

  // Sequence draws and warm-up steps
  clsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Generators, shuffle table and result registers
  clsp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_i        (s_axis_tdata[30:0]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_o       (value),
    .first_state_o (first_state)
  );

  assign m_axis_tdata = {2'b00, first_state, value};

endmodule
`default_nettype wire

[src/clsp_ctrl.sv]
`default_nettype none
module clsp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  input  wire logic              s_tuser_i,
  output logic                   s_tready_o,
  input  wire logic              m_tready_i,
  output logic                   m_tvalid_o,
  input  wire clsp_pkg::dp_sts_t sts_i,
  output clsp_pkg::dp_cmd_t      cmd_o
);
  import clsp_pkg::*;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   out_free;
  logic   reseed;

  assign out_free   = !m_valid_q || m_tready_i;
  assign m_tvalid_o = m_valid_q;

  // Reseed on command, or when the first generator would be zero at draw time
  assign reseed = s_tuser_i ||
                  ((state_q == ST_DRAW_RED) ? sts_i.red_one_zero : sts_i.gen_one_zero);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          state_d = reseed ? ST_SEED_MUL : ST_DRAW_MUL;
        end
      end
      ST_SEED_MUL: state_d = ST_SEED_RED;
      ST_SEED_RED: state_d = sts_i.cnt_zero ? ST_DRAW_MUL : ST_SEED_MUL;
      ST_DRAW_MUL: state_d = ST_DRAW_RED;
      ST_DRAW_RED: begin
        if (out_free) begin
          if (s_tvalid_i) begin
            state_d = reseed ? ST_SEED_MUL : ST_DRAW_MUL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o       = 1'b1;
        cmd_o.load       = s_tvalid_i && reseed;
        cmd_o.load_one   = !s_tuser_i;
      end
      ST_SEED_MUL: cmd_o.mul_en    = 1'b1;
      ST_SEED_RED: cmd_o.warm_step = 1'b1;
      ST_DRAW_MUL: cmd_o.mul_en    = 1'b1;
      ST_DRAW_RED: begin
        // Commit only when the result register can take the item
        if (out_free) begin
          cmd_o.draw_commit = 1'b1;
          s_tready_o        = 1'b1;
          cmd_o.load        = s_tvalid_i && reseed;
          cmd_o.load_one    = !s_tuser_i;
        end
      end
      default: begin
        cmd_o      = '0;
        s_tready_o = 1'b0;
      end
    endcase
  end

  // Hold result valid until taken
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.draw_commit) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  `include "combined_lcg_shuffled_prng_top_assert.svh"

  `CLSP_ASSERT_NOW(a_commit_room, cmd_o.draw_commit, !m_valid_q || m_tready_i, "commit with full output")
  `CLSP_ASSERT_NOW(a_ready_states, s_tready_o, state_q == ST_IDLE || state_q == ST_DRAW_RED, "ready in busy state")
  `CLSP_ASSERT_NEXT(a_load_warm, s_tvalid_i && s_tready_o && reseed, state_q == ST_SEED_MUL, "reseed without warm-up")

endmodule
`default_nettype wire

[src/clsp_dp.sv]
`default_nettype none
module clsp_dp #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [30:0]       seed_i,
  input  wire clsp_pkg::dp_cmd_t cmd_i,
  output clsp_pkg::dp_sts_t      sts_o,
  output logic [30:0]            value_o,
  output logic [30:0]            first_state_o
);
  import clsp_pkg::*;

  localparam int unsigned IdxW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW    = $clog2(TABLE_DEPTH + WARMUP_EXTRA);
  localparam longint unsigned SlotDiv =
    64'd1 + (64'(MOD_ONE) - 64'd1) / 64'(TABLE_DEPTH);

  logic [30:0] gen_one_q, gen_one_d;
  logic [30:0] gen_two_q, gen_two_d;
  logic [30:0] last_out_q, last_out_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [PROD_W-1:0] prod1_q, prod2_q;
  logic [IdxW-1:0]   slot, slot_q;
  logic [30:0]       rd_q;
  logic [30:0]       value_q, first_q;

  logic [30:0] tbl_mem [TABLE_DEPTH];

  logic [30:0] seed_eff;
  logic [31:0] sum1, sum2;
  logic [30:0] red1, red2;
  logic [31:0] diff, wrapped;
  logic        diff_nonpos;
  logic [TABLE_DEPTH:0] ge;
  logic        cnt_in_tbl;
  logic        tbl_we;
  logic [IdxW-1:0] tbl_wa;

  // Seed of zero, or an unseeded draw, acts as one
  assign seed_eff = (cmd_i.load_one || (seed_i == '0)) ? 31'd1 : seed_i;

  // Fold upper product bits by 2^31 mod M, then one conditional subtract
  assign sum1 = {1'b0, prod1_q[30:0]} + (32'(prod1_q[PROD_W-1:31]) * FOLD_ONE);
  assign sum2 = {1'b0, prod2_q[30:0]} + (32'(prod2_q[PROD_W-1:31]) * FOLD_TWO);
  assign red1 = (sum1 >= MOD_ONE) ? 31'(sum1 - MOD_ONE) : sum1[30:0];
  assign red2 = (sum2 >= MOD_TWO) ? 31'(sum2 - MOD_TWO) : sum2[30:0];

  // Shuffled output: table entry minus second generator, wrapped to 1..M1-1
  assign diff        = {1'b0, rd_q} - {1'b0, red2};
  assign diff_nonpos = diff[31] || (diff == '0);
  assign wrapped     = diff_nonpos ? (diff + WRAP_ADD) : diff;

  // Slot from previous output: compare against multiples of the slot width
  always_comb begin
    ge[0]           = 1'b1;
    ge[TABLE_DEPTH] = 1'b0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      ge[k] = 64'(last_out_q) >= (64'(k) * SlotDiv);
    end
  end

  always_comb begin
    slot = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if (ge[k] && !ge[k+1]) begin
        slot = slot | IdxW'(k);
      end
    end
  end

  assign cnt_in_tbl = cnt_q < CntW'(TABLE_DEPTH);

  // Table write port: warm-up fill or draw refill
  assign tbl_we = (cmd_i.warm_step && cnt_in_tbl) || cmd_i.draw_commit;
  assign tbl_wa = cmd_i.warm_step ? cnt_q[IdxW-1:0] : slot_q;

  // Generator, last output and warm-up count updates
  always_comb begin
    gen_one_d  = gen_one_q;
    gen_two_d  = gen_two_q;
    last_out_d = last_out_q;
    cnt_d      = cnt_q;
    if (cmd_i.draw_commit) begin
      gen_one_d  = red1;
      gen_two_d  = red2;
      last_out_d = wrapped[30:0];
    end
    if (cmd_i.warm_step) begin
      gen_one_d = red1;
      if (cnt_q == '0) begin
        last_out_d = red1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
    if (cmd_i.load) begin
      gen_one_d = seed_eff;
      gen_two_d = seed_eff;
      cnt_d     = CntW'(TABLE_DEPTH + WARMUP_EXTRA - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_one_q  <= '0;
      gen_two_q  <= TWO_SEED;
      last_out_q <= '0;
      cnt_q      <= '0;
    end else begin
      gen_one_q  <= gen_one_d;
      gen_two_q  <= gen_two_d;
      last_out_q <= last_out_d;
      cnt_q      <= cnt_d;
    end
  end

  // Multiply stage and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod1_q <= PROD_W'(gen_one_q) * PROD_W'(MUL_ONE);
      prod2_q <= PROD_W'(gen_two_q) * PROD_W'(MUL_TWO);
      slot_q  <= slot;
    end
    if (cmd_i.draw_commit) begin
      value_q <= wrapped[30:0];
      first_q <= red1;
    end
  end

  // Shuffle table memory, registered read
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= red1;
    end
    if (cmd_i.mul_en) begin
      rd_q <= tbl_mem[slot];
    end
  end

  assign sts_o.gen_one_zero = (gen_one_q == '0);
  assign sts_o.red_one_zero = (red1 == '0);
  assign sts_o.cnt_zero     = (cnt_q == '0);

  assign value_o       = value_q;
  assign first_state_o = first_q;

  `include "combined_lcg_shuffled_prng_top_assert.svh"

  `CLSP_ASSERT_NOW(a_red_range, cmd_i.warm_step || cmd_i.draw_commit, 32'(red1) < MOD_ONE && 32'(red2) < MOD_TWO, "reduction out of range")
  `CLSP_ASSERT_NOW(a_value_range, cmd_i.draw_commit, wrapped[30:0] != '0 && 32'(wrapped[30:0]) < MOD_ONE, "output out of range")
  `CLSP_ASSERT_NEXT(a_warm_last, cmd_i.warm_step && cnt_q == '0, last_out_q == gen_one_q, "last output not loaded at warm-up end")

endmodule
`default_nettype wire

[bench/combined_lcg_shuffled_prng_top_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module combined_lcg_shuffled_prng_top_tb;
  import clsp_pkg::*;

  localparam int unsigned TBL_DEPTH      = 32;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned HOLD_AT_RESULT = 200;
  localparam int unsigned PAUSE_AT_ITEM  = 600;
  localparam logic [31:0] SLOT_SPAN      = 32'd1 + (MOD_ONE - 32'd1) / TBL_DEPTH;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_RESEED = 1'b1
  } command_e;

  // One result: shuffled value and first generator state
  typedef struct packed {
    logic [30:0] value;
    logic [30:0] first_state;
  } draw_t;

  // Directed row; pin marks a first_state that is known without the predictor
  typedef struct packed {
    command_e    cmd;
    logic [30:0] seed;
    logic        pin;
    logic [30:0] pinned_state;
  } vector_t;

  localparam int unsigned N_DIRECTED = 22;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  // Predictor state
  logic [30:0] gen_a;
  logic [30:0] gen_b;
  logic [30:0] prev_value;
  logic [30:0] shuffle [TBL_DEPTH];

  draw_t expected_draws[$];
  int    mismatch_count = 0;

  vector_t directed [N_DIRECTED] = '{
    '{CMD_DRAW,   31'd0,              1'b0, 31'd0},  // draw straight after reset
    '{CMD_DRAW,   31'h7FFF_FFFF,      1'b0, 31'd0},  // seed ignored on a draw
    '{CMD_RESEED, 31'd0,              1'b0, 31'd0},  // zero seed acts as one
    '{CMD_DRAW,   31'd0,              1'b0, 31'd0},
    '{CMD_RESEED, 31'd1,              1'b0, 31'd0},
    '{CMD_RESEED, 31'h7FFF_FFFF,      1'b0, 31'd0},  // seed above both moduli
    '{CMD_DRAW,   31'h2AAA_AAAA,      1'b0, 31'd0},
    '{CMD_RESEED, 31'(MOD_ONE),       1'b1, 31'd0},  // first generator collapses to zero
    '{CMD_DRAW,   31'd0,              1'b0, 31'd0},  // zero state reseeds with one
    '{CMD_RESEED, 31'(MOD_ONE - 1),   1'b0, 31'd0},
    '{CMD_RESEED, 31'(MOD_TWO),       1'b0, 31'd0},
    '{CMD_RESEED, 31'(MOD_TWO - 1),   1'b0, 31'd0},
    '{CMD_RESEED, 31'(MOD_ONE + 1),   1'b0, 31'd0},
    '{CMD_RESEED, 31'h2AAA_AAAA,      1'b0, 31'd0},
    '{CMD_RESEED, 31'h5555_5555,      1'b0, 31'd0},
    '{CMD_DRAW,   31'd0,              1'b0, 31'd0},
    '{CMD_DRAW,   31'h5555_5555,      1'b0, 31'd0},
    '{CMD_DRAW,   31'd0,              1'b0, 31'd0},
    '{CMD_DRAW,   31'd0,              1'b0, 31'd0},
    '{CMD_DRAW,   31'd0,              1'b0, 31'd0},
    '{CMD_RESEED, 31'(MOD_ONE),       1'b1, 31'd0},
    '{CMD_RESEED, 31'h4000_0000,      1'b0, 31'd0}   // reseed while state is zero
  };

  combined_lcg_shuffled_prng_top #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Advance both generators by one accepted item and return its result
  function automatic draw_t advance_generators(input command_e cmd, input logic [30:0] seed);
    logic [63:0] wide;
    logic [30:0] load_val;
    logic [31:0] slot;
    longint      diff;
    int          n;
    draw_t       res;
    if (cmd == CMD_RESEED || gen_a == '0) begin
      load_val = (cmd == CMD_RESEED && seed != '0) ? seed : 31'd1;
      gen_a = load_val;
      gen_b = load_val;
      // warm up, filling the table from the top slot down
      for (n = TBL_DEPTH + WARMUP_EXTRA - 1; n >= 0; n--) begin
        wide  = (64'(gen_a) * 64'(MUL_ONE)) % 64'(MOD_ONE);
        gen_a = wide[30:0];
        if (n < TBL_DEPTH) shuffle[n] = gen_a;
      end
      prev_value = shuffle[0];
    end
    wide  = (64'(gen_a) * 64'(MUL_ONE)) % 64'(MOD_ONE);
    gen_a = wide[30:0];
    wide  = (64'(gen_b) * 64'(MUL_TWO)) % 64'(MOD_TWO);
    gen_b = wide[30:0];
    slot = 32'(prev_value) / SLOT_SPAN;
    if (slot >= TBL_DEPTH) slot = TBL_DEPTH - 1;
    diff = longint'(shuffle[slot]) - longint'(gen_b);
    shuffle[slot] = gen_a;
    if (diff < 1) diff += longint'(WRAP_ADD);
    prev_value      = diff[30:0];
    res.value       = prev_value;
    res.first_state = gen_a;
    return res;
  endfunction

  // Offer one item after a gap; record its result once accepted
  task automatic offer_item(input command_e cmd, input logic [30:0] seed, input int gap,
                            input logic pin, input logic [30:0] pinned_state);
    draw_t want;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, seed};
    do @(posedge clk_i); while (!s_axis_tready);
    want = advance_generators(cmd, seed);
    if (pin) want.first_state = pinned_state;
    expected_draws.push_back(want);
    @(negedge clk_i);
  endtask

  // Stimulus: reset, directed rows, then random items
  initial begin
    int          i;
    int          gap;
    command_e    cmd;
    logic [30:0] seed;
    gen_a      = '0;
    gen_b      = TWO_SEED;
    prev_value = '0;
    foreach (shuffle[k]) shuffle[k] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < N_DIRECTED; i++) begin
      offer_item(directed[i].cmd, directed[i].seed, $urandom_range(0, 10),
                 directed[i].pin, directed[i].pinned_state);
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // hold off until every result is back
      if (i == PAUSE_AT_ITEM) begin
        s_axis_tvalid <= 1'b0;
        while (expected_draws.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      cmd = ($urandom_range(0, 15) == 0) ? CMD_RESEED : CMD_DRAW;
      case ($urandom_range(0, 15))
        0:       seed = '0;
        1:       seed = 31'(MOD_ONE);
        2:       seed = 31'(MOD_TWO);
        3:       seed = 31'h7FFF_FFFF;
        default: seed = 31'($urandom());
      endcase
      gap = ((i / 100) % 3 == 0) ? 0 : $urandom_range(0, 10);
      offer_item(cmd, seed, gap, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_draws.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: random stalls, stall-free stretches and one long hold
  initial begin
    int stall;
    int drained;
    drained = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (drained == HOLD_AT_RESULT) begin
        stall = LONG_HOLD;
      end else if ((drained / 50) % 3 == 0) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 10);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      drained++;
      @(negedge clk_i);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    draw_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_draws.size() == 0) begin
        $error("result with none pending: value %0d first_state %0d",
               m_axis_tdata[30:0], m_axis_tdata[61:31]);
        mismatch_count++;
      end else begin
        want = expected_draws.pop_front();
        if (m_axis_tdata[30:0] !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, m_axis_tdata[30:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[61:31] !== want.first_state) begin
          $error("first_state: expected %0d, got %0d", want.first_state, m_axis_tdata[61:31]);
          mismatch_count++;
        end
        if (m_axis_tdata[63:62] !== 2'b00) begin
          $error("padding: expected 0, got %0d", m_axis_tdata[63:62]);
          mismatch_count++;
        end
      end
    end
  end

  // End the run when neither side moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
